// ===== design/hsgpd_pkg.sv =====
package hsgpd_pkg;

	// Limits applied to the frame layout registers.
	localparam int MAX_HEADER_BITS  = 16;
	localparam int MAX_PACKAGE_BITS = 64;
	localparam int MAX_PACKAGES     = 64;

	// Register reset values.
	localparam logic [15:0] HDR_PATTERN_RST = 16'd31;
	localparam logic [4:0]  HDR_LENGTH_RST  = 5'd5;
	localparam logic [6:0]  PKG_SIZE_RST    = 7'd4;
	localparam logic [6:0]  PKG_COUNT_RST   = 7'd1;
	localparam logic [3:0]  GUARD_SIZE_RST  = 4'd1;

	// Register indexes on the configuration port.
	typedef enum logic [2:0] {
		REG_HDR_PATTERN = 3'd0,
		REG_HDR_LENGTH  = 3'd1,
		REG_PKG_SIZE    = 3'd2,
		REG_PKG_COUNT   = 3'd3,
		REG_GUARD_SIZE  = 3'd4
	} reg_idx_t;

	// Result kinds.
	typedef enum logic [1:0] {
		KIND_PAYLOAD  = 2'd0,
		KIND_COMPLETE = 2'd1,
		KIND_ABANDON  = 2'd2
	} kind_t;

	// Configuration register set.
	typedef struct packed {
		logic [15:0] hdr_pattern;
		logic [4:0]  hdr_length;
		logic [6:0]  pack_bits;
		logic [6:0]  pack_num;
		logic [3:0]  guard_bits;
	} cfg_t;

	// All results caused by one item: a first result and an optional second.
	// The second one is always a status result with zero payload fields.
	typedef struct packed {
		logic        two;
		kind_t       kind0;
		logic        bit0;
		logic [5:0]  pkg0;
		kind_t       kind1;
	} run_t;

endpackage

// ===== design/hsgpd_core.sv =====
module hsgpd_core import hsgpd_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  cfg_t cfg,
	input  logic take,
	input  logic line_bit,
	input  logic stream_end,
	output logic run_has,
	output run_t run
);

	logic [15:0] window_q, window_d;
	logic [4:0]  fill_q, fill_d;
	logic        in_frame_q, in_frame_d;
	logic        in_guard_q, in_guard_d;
	logic [5:0]  pos_q, pos_d;
	logic [6:0]  pkg_q, pkg_d;

	logic [4:0]  hlen;
	logic [6:0]  psize;
	logic [6:0]  pcount;
	logic [15:0] win_shift;
	logic [4:0]  fill_inc;
	logic [16:0] mask_full;
	logic        hdr_match;
	logic [5:0]  pos_inc;
	logic [6:0]  pkg_inc;

	// Out-of-range register values are clamped into the legal range.
	always_comb begin
		if (cfg.hdr_length == 5'd0) begin
			hlen = 5'd1;
		end else if (cfg.hdr_length > 5'(MAX_HEADER_BITS)) begin
			hlen = 5'(MAX_HEADER_BITS);
		end else begin
			hlen = cfg.hdr_length;
		end
		if (cfg.pack_bits == 7'd0) begin
			psize = 7'd1;
		end else if (cfg.pack_bits > 7'(MAX_PACKAGE_BITS)) begin
			psize = 7'(MAX_PACKAGE_BITS);
		end else begin
			psize = cfg.pack_bits;
		end
		if (cfg.pack_num == 7'd0) begin
			pcount = 7'd1;
		end else if (cfg.pack_num > 7'(MAX_PACKAGES)) begin
			pcount = 7'(MAX_PACKAGES);
		end else begin
			pcount = cfg.pack_num;
		end
	end

	// Header search over the newest hlen bits of the sliding window.
	assign win_shift = {window_q[14:0], line_bit};
	assign fill_inc  = (fill_q < 5'd16) ? fill_q + 5'd1 : fill_q;
	assign mask_full = (17'd1 << hlen) - 17'd1;
	assign hdr_match = (fill_inc >= hlen) &&
		(((win_shift ^ cfg.hdr_pattern) & mask_full[15:0]) == 16'd0);

	assign pos_inc = pos_q + 6'd1;
	assign pkg_inc = pkg_q + 7'd1;

	// Next state and the results of the current item.
	always_comb begin
		window_d   = window_q;
		fill_d     = fill_q;
		in_frame_d = in_frame_q;
		in_guard_d = in_guard_q;
		pos_d      = pos_q;
		pkg_d      = pkg_q;
		run_has    = 1'b0;
		run.two    = 1'b0;
		run.kind0  = KIND_PAYLOAD;
		run.bit0   = 1'b0;
		run.pkg0   = 6'd0;
		run.kind1  = KIND_ABANDON;

		if (!in_frame_q) begin
			// Hunting: shift the bit in and look for the header.
			window_d = win_shift;
			fill_d   = fill_inc;
			if (hdr_match) begin
				window_d   = 16'd0;
				fill_d     = 5'd0;
				in_frame_d = 1'b1;
				in_guard_d = (cfg.guard_bits != 4'd0);
				pos_d      = 6'd0;
				pkg_d      = 7'd0;
			end
		end else if (in_guard_q) begin
			// Guard bits give no result, except that the end of the last guard finishes the frame
			// with a complete result; the end of any other guard opens a package.
			pos_d = pos_inc;
			if (pos_inc >= {2'b00, cfg.guard_bits}) begin
				pos_d = 6'd0;
				if (pkg_q >= pcount) begin
					in_frame_d = 1'b0;
					in_guard_d = 1'b0;
					pkg_d      = 7'd0;
					window_d   = 16'd0;
					fill_d     = 5'd0;
					run_has    = 1'b1;
					run.kind0  = KIND_COMPLETE;
				end else begin
					in_guard_d = 1'b0;
				end
			end
		end else begin
			// Payload bit goes out at once with its package index.
			run_has   = 1'b1;
			run.kind0 = KIND_PAYLOAD;
			run.bit0  = line_bit;
			run.pkg0  = pkg_q[5:0];
			pos_d     = pos_inc;
			if (pos_inc == 6'd0 || {1'b0, pos_inc} >= psize) begin
				pos_d      = 6'd0;
				pkg_d      = pkg_inc;
				in_guard_d = 1'b1;
				// With no guard the frame may finish on this same bit.
				if (cfg.guard_bits == 4'd0) begin
					if (pkg_inc >= pcount) begin
						in_frame_d = 1'b0;
						in_guard_d = 1'b0;
						pkg_d      = 7'd0;
						window_d   = 16'd0;
						fill_d     = 5'd0;
						run.two    = 1'b1;
						run.kind1  = KIND_COMPLETE;
					end else begin
						in_guard_d = 1'b0;
					end
				end
			end
		end

		// Stream end abandons an open frame and always restarts the hunt.
		if (stream_end) begin
			if (in_frame_d) begin
				if (run_has) begin
					run.two   = 1'b1;
					run.kind1 = KIND_ABANDON;
				end else begin
					run_has   = 1'b1;
					run.kind0 = KIND_ABANDON;
				end
			end
			in_frame_d = 1'b0;
			in_guard_d = 1'b0;
			pos_d      = 6'd0;
			pkg_d      = 7'd0;
			window_d   = 16'd0;
			fill_d     = 5'd0;
		end
	end

	// State registers advance on each accepted item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q   <= 16'd0;
			fill_q     <= 5'd0;
			in_frame_q <= 1'b0;
			in_guard_q <= 1'b0;
			pos_q      <= 6'd0;
			pkg_q      <= 7'd0;
		end else if (take) begin
			window_q   <= window_d;
			fill_q     <= fill_d;
			in_frame_q <= in_frame_d;
			in_guard_q <= in_guard_d;
			pos_q      <= pos_d;
			pkg_q      <= pkg_d;
		end
	end

endmodule

// ===== design/header_sync_guarded_packet_deframer.sv =====
// Results of an accepted item are registered in the result queue and shown once earlier entries are taken.
// Throughput: one item per cycle while the two-entry result queue is not full; an item with
// two results occupies the output until both are taken, and a full queue holds back the input.
// Reset (arst_n low) empties the result queue, returns to header hunting with an
// empty window, and loads the register reset values.
module header_sync_guarded_packet_deframer import hsgpd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	// APB-style configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// Input channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        line_bit,
	input  logic        stream_end,
	// Output channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  kind,
	output logic        payload_bit,
	output logic [5:0]  package_index,
	output logic        last_of_run
);

	cfg_t     cfg_q;
	reg_idx_t reg_idx;
	logic     cfg_wr;
	logic     take;
	logic     run_has;
	run_t     run;
	run_t     queue_q [2];
	run_t     head;
	logic     wr_ptr_q;
	logic     rd_ptr_q;
	logic [1:0] cnt_q;
	logic     sub_q;
	logic     out_take;
	logic     push;
	logic     pop;

	// Configuration registers.
	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[4:2]);
	assign cfg_wr  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.hdr_pattern <= HDR_PATTERN_RST;
			cfg_q.hdr_length  <= HDR_LENGTH_RST;
			cfg_q.pack_bits   <= PKG_SIZE_RST;
			cfg_q.pack_num    <= PKG_COUNT_RST;
			cfg_q.guard_bits  <= GUARD_SIZE_RST;
		end else if (cfg_wr) begin
			case (reg_idx)
				REG_HDR_PATTERN: cfg_q.hdr_pattern <= pwdata[15:0];
				REG_HDR_LENGTH:  cfg_q.hdr_length  <= pwdata[4:0];
				REG_PKG_SIZE:    cfg_q.pack_bits   <= pwdata[6:0];
				REG_PKG_COUNT:   cfg_q.pack_num    <= pwdata[6:0];
				REG_GUARD_SIZE:  cfg_q.guard_bits  <= pwdata[3:0];
				default: ;
			endcase
		end
	end

	// Register read-back.
	always_comb begin
		case (reg_idx)
			REG_HDR_PATTERN: prdata = {16'd0, cfg_q.hdr_pattern};
			REG_HDR_LENGTH:  prdata = {27'd0, cfg_q.hdr_length};
			REG_PKG_SIZE:    prdata = {25'd0, cfg_q.pack_bits};
			REG_PKG_COUNT:   prdata = {25'd0, cfg_q.pack_num};
			REG_GUARD_SIZE:  prdata = {28'd0, cfg_q.guard_bits};
			default:         prdata = 32'd0;
		endcase
	end

	// Frame tracking for each accepted item.
	assign in_stall = cnt_q[1];
	assign take     = in_valid && !in_stall;

	hsgpd_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.take       (take),
		.line_bit   (line_bit),
		.stream_end (stream_end),
		.run_has    (run_has),
		.run        (run)
	);

	// Result queue: each entry holds all results of one item.
	assign head      = queue_q[rd_ptr_q];
	assign out_valid = (cnt_q != 2'd0);
	assign out_take  = out_valid && !out_stall;
	assign push      = take && run_has;
	assign pop       = out_take && (sub_q || !head.two);

	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q] <= run;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
			sub_q    <= 1'b0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
			if (out_take) begin
				sub_q <= head.two && !sub_q;
			end
		end
	end

	// The second result of an entry is a status result with zero payload fields.
	assign kind          = sub_q ? head.kind1 : head.kind0;
	assign payload_bit   = sub_q ? 1'b0 : head.bit0;
	assign package_index = sub_q ? 6'd0 : head.pkg0;
	assign last_of_run   = sub_q || !head.two;

endmodule

// ===== design/hsgpd_checker.sv =====
module hsgpd_checker import hsgpd_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic [1:0] kind,
	input logic       payload_bit,
	input logic [5:0] package_index,
	input logic       last_of_run
);

	// A stalled result holds until it is taken.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(kind) && $stable(payload_bit) &&
			$stable(package_index) && $stable(last_of_run))
		else $error("stalled result changed");

	// A result that is not the last of its item is followed at once by a status result.
	a_run_follow: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !last_of_run |=> out_valid && kind != KIND_PAYLOAD)
		else $error("second result of an item missing or not a status result");

	// The input is held back only while results are waiting.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("input stalled with no result pending");

endmodule

bind header_sync_guarded_packet_deframer hsgpd_checker u_hsgpd_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_stall      (in_stall),
	.out_valid     (out_valid),
	.out_stall     (out_stall),
	.kind          (kind),
	.payload_bit   (payload_bit),
	.package_index (package_index),
	.last_of_run   (last_of_run)
);

// ===== sim/header_sync_guarded_packet_deframer_tb.sv =====
`timescale 1ns / 1ps

module header_sync_guarded_packet_deframer_tb;
	import hsgpd_pkg::*;

	localparam int QUIET_LIMIT = 3000;
	localparam int HOLD_CYCLES = 400;
	localparam int HOLD_AFTER  = 1000;
	localparam int PHASE_ITEMS = 200;
	localparam int NUM_PHASES  = 8;

	typedef struct packed {
		logic lb;
		logic eos;
	} line_item_t;

	typedef struct packed {
		kind_t      kind;
		logic       pbit;
		logic [5:0] pkg;
		logic       last;
	} deframed_t;

	typedef enum logic [1:0] {
		STALL_NONE   = 2'd0,
		STALL_HALF   = 2'd1,
		STALL_HEAVY  = 2'd2,
		STALL_TOGGLE = 2'd3
	} stall_mode_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [4:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic        line_bit = 1'b0;
	logic        stream_end = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [1:0]  kind;
	logic        payload_bit;
	logic [5:0]  package_index;
	logic        last_of_run;

	header_sync_guarded_packet_deframer dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.line_bit      (line_bit),
		.stream_end    (stream_end),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.kind          (kind),
		.payload_bit   (payload_bit),
		.package_index (package_index),
		.last_of_run   (last_of_run)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Shadow copy of the registers and of the deframer state.
	cfg_t        line_cfg = {HDR_PATTERN_RST, HDR_LENGTH_RST, PKG_SIZE_RST, PKG_COUNT_RST,
		GUARD_SIZE_RST};
	logic [15:0] hunt_window = '0;
	logic [4:0]  hunt_fill = '0;
	logic        framing = 1'b0;
	logic        guarding = 1'b0;
	logic [5:0]  run_pos = '0;
	logic [6:0]  pkg_no = '0;

	line_item_t  line_bits_q[$];
	deframed_t   deframed_due[$];
	line_item_t  next_bit;
	deframed_t   seen_want;
	int          errors = 0;

	function automatic int clamp_len(int v, int hi);
		if (v < 1)
			return 1;
		return (v > hi) ? hi : v;
	endfunction

	function automatic void rehunt();
		framing = 1'b0;
		guarding = 1'b0;
		run_pos = '0;
		pkg_no = '0;
		hunt_window = '0;
		hunt_fill = '0;
	endfunction

	// A guard run is over: open the next package or close the frame.
	function automatic logic close_guard(int pcnt);
		run_pos = '0;
		if (pkg_no >= pcnt) begin
			rehunt();
			return 1'b1;
		end
		guarding = 1'b0;
		return 1'b0;
	endfunction

	function automatic deframed_t frame_result(kind_t k, logic b, logic [5:0] p);
		deframed_t r;
		r.kind = k;
		r.pbit = b;
		r.pkg = p;
		r.last = 1'b0;
		return r;
	endfunction

	// Advance the shadow deframer by one line bit and queue the results it causes.
	function automatic void deframe_bit(logic lb, logic eos);
		int          hl;
		int          ps;
		int          pc;
		logic [15:0] msk;
		deframed_t   got[$];
		hl = clamp_len(line_cfg.hdr_length, MAX_HEADER_BITS);
		ps = clamp_len(line_cfg.pack_bits, MAX_PACKAGE_BITS);
		pc = clamp_len(line_cfg.pack_num, MAX_PACKAGES);
		if (!framing) begin
			msk = 16'hFFFF >> (16 - hl);
			hunt_window = {hunt_window[14:0], lb};
			if (hunt_fill < 16)
				hunt_fill = hunt_fill + 1;
			if (hunt_fill >= hl && (hunt_window & msk) == (line_cfg.hdr_pattern & msk)) begin
				hunt_window = '0;
				hunt_fill = '0;
				framing = 1'b1;
				guarding = 1'b1;
				run_pos = '0;
				pkg_no = '0;
				if (line_cfg.guard_bits == 0)
					void'(close_guard(pc));
			end
		end else if (guarding) begin
			run_pos = run_pos + 1;
			if (run_pos >= line_cfg.guard_bits && close_guard(pc))
				got.insert(got.size(), frame_result(KIND_COMPLETE, 1'b0, 6'd0));
		end else begin
			got.insert(got.size(), frame_result(KIND_PAYLOAD, lb, pkg_no[5:0]));
			run_pos = run_pos + 1;
			if (run_pos == 0 || run_pos >= ps) begin
				run_pos = '0;
				pkg_no = pkg_no + 1;
				guarding = 1'b1;
				if (line_cfg.guard_bits == 0 && close_guard(pc))
					got.insert(got.size(), frame_result(KIND_COMPLETE, 1'b0, 6'd0));
			end
		end
		// The stream ended: an open frame is abandoned, and hunting restarts.
		if (eos) begin
			if (framing)
				got.insert(got.size(), frame_result(KIND_ABANDON, 1'b0, 6'd0));
			rehunt();
		end
		if (got.size() != 0)
			got[got.size() - 1].last = 1'b1;
		foreach (got[i])
			deframed_due.insert(deframed_due.size(), got[i]);
	endfunction

	function automatic void check_field(string name, int want, int seen);
		if (want != seen) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, seen);
			errors++;
		end
	endfunction

	// Sender: bursts of items from the pending queue with random gaps between them.
	int burst_left = 0;
	int gap_left = 0;

	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			burst_left <= 0;
			gap_left <= 0;
		end else begin
			if (in_valid && !in_stall)
				deframe_bit(line_bit, stream_end);
			if (!in_valid || !in_stall) begin
				if (gap_left != 0) begin
					gap_left <= gap_left - 1;
					in_valid <= 1'b0;
				end else if (line_bits_q.size() != 0) begin
					next_bit = line_bits_q.pop_front();
					in_valid <= 1'b1;
					line_bit <= next_bit.lb;
					stream_end <= next_bit.eos;
					if (burst_left <= 1) begin
						burst_left <= $urandom_range(1, 24);
						gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
					end else begin
						burst_left <= burst_left - 1;
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver: stall modes that change now and then, plus one long hold-off
	// that lets the block fill up and stall its input.
	stall_mode_t stall_mode = STALL_NONE;
	int          mode_left = 0;
	int          hold_left = 0;
	int          taken_in = 0;
	logic        held = 1'b0;

	always @(posedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			taken_in <= 0;
		end else begin
			if (in_valid && !in_stall)
				taken_in <= taken_in + 1;
			if (hold_left != 0) begin
				out_stall <= 1'b1;
				hold_left <= hold_left - 1;
			end else if (!held && taken_in >= HOLD_AFTER && line_bits_q.size() >= 16) begin
				// Start the hold-off only while the sender still has items to offer.
				held <= 1'b1;
				hold_left <= HOLD_CYCLES;
				out_stall <= 1'b1;
			end else begin
				if (mode_left == 0) begin
					stall_mode <= stall_mode_t'($urandom_range(0, 3));
					mode_left <= $urandom_range(32, 200);
				end else begin
					mode_left <= mode_left - 1;
				end
				case (stall_mode)
					STALL_NONE: out_stall <= 1'b0;
					STALL_HALF: out_stall <= ($urandom_range(0, 1) == 1);
					STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
					default: out_stall <= !out_stall;
				endcase
			end
		end
	end

	// Each accepted result is compared with the oldest expected one.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (deframed_due.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual kind %0d bit %0d pkg %0d",
					$time, kind, payload_bit, package_index);
				errors++;
			end else begin
				seen_want = deframed_due.pop_front();
				check_field("kind", seen_want.kind, kind);
				check_field("payload_bit", seen_want.pbit, payload_bit);
				check_field("package_index", seen_want.pkg, package_index);
				check_field("last_of_run", seen_want.last, last_of_run);
			end
		end
	end

	// Watchdog on cycles in which nothing moves on any port.
	int quiet = 0;

	always @(posedge clk) begin
		if (!arst_n || psel || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet <= 0;
		end else if (quiet >= QUIET_LIMIT) begin
			$display("%0t: no progress for %0d cycles", $time, QUIET_LIMIT);
			$display("CHECKS FAILED");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	task automatic push_bit(input logic lb, input logic eos);
		line_item_t it;
		it.lb = lb;
		it.eos = eos;
		line_bits_q.insert(line_bits_q.size(), it);
	endtask

	task automatic reg_write(input reg_idx_t idx, input logic [31:0] val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_HDR_PATTERN: line_cfg.hdr_pattern = val[15:0];
			REG_HDR_LENGTH: line_cfg.hdr_length = val[4:0];
			REG_PKG_SIZE: line_cfg.pack_bits = val[6:0];
			REG_PKG_COUNT: line_cfg.pack_num = val[6:0];
			REG_GUARD_SIZE: line_cfg.guard_bits = val[3:0];
			default: ;
		endcase
	endtask

	// Wait until every item is taken and every result has come, then let the
	// block settle on items that cause no result.
	task automatic wait_idle();
		do
			@(posedge clk);
		while (line_bits_q.size() != 0 || in_valid || deframed_due.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	// Mostly well-formed frames with random content, some cut short by a stream
	// end, and some noise between them.
	task automatic fill_phase(input int budget);
		int hl;
		int ps;
		int pc;
		int body;
		int stop;
		int span;
		int k;
		int n;
		hl = clamp_len(line_cfg.hdr_length, MAX_HEADER_BITS);
		ps = clamp_len(line_cfg.pack_bits, MAX_PACKAGE_BITS);
		pc = clamp_len(line_cfg.pack_num, MAX_PACKAGES);
		body = line_cfg.guard_bits + pc * (ps + line_cfg.guard_bits);
		n = 0;
		while (n < budget) begin
			k = $urandom_range(0, 9);
			if (k < 8) begin
				if (k == 7)
					stop = $urandom_range(hl - 1, hl + body - 2);
				else if ($urandom_range(0, 3) == 0)
					stop = hl + body - 1;
				else
					stop = -1;
				span = (k == 7) ? stop + 1 : hl + body;
				for (int j = 0; j < span; j++)
					push_bit((j < hl) ? line_cfg.hdr_pattern[hl - 1 - j] :
						($urandom_range(0, 1) != 0), j == stop);
				n += span;
			end else begin
				span = $urandom_range(1, 8);
				for (int j = 0; j < span; j++)
					push_bit($urandom_range(0, 1) != 0, $urandom_range(0, 15) == 0);
				n += span;
			end
		end
	endtask

	initial begin
		logic [15:0] pat;
		logic [4:0]  hlen;
		logic [6:0]  psz;
		logic [6:0]  pcnt;
		logic [3:0]  gsz;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Reset layout: header of five ones, one guard bit, one package of four.
		// A complete frame first.
		repeat (5) push_bit(1'b1, 1'b0);
		push_bit(1'b0, 1'b0);
		push_bit(1'b1, 1'b0);
		push_bit(1'b0, 1'b0);
		push_bit(1'b1, 1'b0);
		push_bit(1'b0, 1'b0);
		push_bit(1'b1, 1'b0);
		// Stream end inside a package: a payload bit and then an abandoned frame.
		repeat (5) push_bit(1'b1, 1'b0);
		push_bit(1'b1, 1'b0);
		push_bit(1'b0, 1'b0);
		push_bit(1'b1, 1'b1);
		// Stream end while hunting gives nothing.
		push_bit(1'b0, 1'b1);
		// A header completed by the last bit of the stream is abandoned at once.
		repeat (4) push_bit(1'b1, 1'b0);
		push_bit(1'b1, 1'b1);
		wait_idle();

		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			pat = $urandom_range(0, 65535);
			hlen = $urandom_range(1, 16);
			psz = $urandom_range(1, 6);
			pcnt = $urandom_range(1, 4);
			gsz = $urandom_range(0, 3);
			case (ph)
				0: begin
					pat = 16'hFFFF;
					hlen = 5'd16;
					psz = 7'd64;
					pcnt = 7'd2;
					gsz = 4'd15;
				end
				1: begin
					hlen = 5'd1;
					psz = 7'd1;
					pcnt = 7'd1;
					gsz = 4'd0;
				end
				// Zero values act as one.
				2: begin
					hlen = 5'd0;
					psz = 7'd0;
					pcnt = 7'd0;
					gsz = 4'd0;
				end
				// Values past the limits act as the limits.
				3: begin
					hlen = 5'd31;
					psz = 7'd127;
					pcnt = 7'd1;
					gsz = 4'd1;
				end
				4: begin
					hlen = 5'd8;
					psz = 7'd1;
					pcnt = 7'd127;
					gsz = 4'd0;
				end
				5: begin
					pat = 16'h0000;
					hlen = 5'd12;
					psz = 7'd2;
					pcnt = 7'd64;
					gsz = 4'd1;
				end
				default: ;
			endcase
			reg_write(REG_HDR_PATTERN, {16'd0, pat});
			reg_write(REG_HDR_LENGTH, {27'd0, hlen});
			reg_write(REG_PKG_SIZE, {25'd0, psz});
			reg_write(REG_PKG_COUNT, {25'd0, pcnt});
			reg_write(REG_GUARD_SIZE, {28'd0, gsz});
			fill_phase(PHASE_ITEMS);
			wait_idle();
		end

		repeat (8) @(posedge clk);
		if (errors == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
